// ===== rtl/core/radial_gradient_color_ramp_defines.svh =====
// Assertion macros shared by the gradient ramp RTL.
`ifndef RADIAL_GRADIENT_COLOR_RAMP_DEFINES_SVH
`define RADIAL_GRADIENT_COLOR_RAMP_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define RGCR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define RGCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rgcr_pkg.sv =====
// Types and constants of the radial gradient color ramp.
package rgcr_pkg;

  localparam int MAX_STOPS = 16;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 12;
  localparam int COLOR_W   = 8;
  localparam int CNT_W     = 5;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = $clog2(MAX_STOPS);
  localparam int POS_W     = FRAC_BITS + 1;

  // distance/radius datapath
  localparam int D2_W      = 2 * COORD_W + 1;
  localparam int QF_BITS   = 2 * FRAC_BITS + 2;
  localparam int Q_W       = QF_BITS + 1;
  localparam int SQ_STEPS  = (Q_W + 1) / 2;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int SREM_W    = ROOT_W + 2;

  // color interpolation datapath
  localparam int NUM_W     = COLOR_W + POS_W + 1;
  localparam int DIV_STEPS = COLOR_W;
  localparam int SH_W      = $clog2(COLOR_W);

  // pipeline positions
  localparam int P_DIV0    = 1;
  localparam int P_SQ0     = P_DIV0 + QF_BITS + 1;
  localparam int P_LUT     = P_SQ0 + SQ_STEPS;
  localparam int P_MIX     = P_LUT + 1;
  localparam int P_CDIV0   = P_MIX + 1;
  localparam int N_POS     = P_CDIV0 + DIV_STEPS;

  localparam logic [POS_W-1:0] POS_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANCHOR_X   = 3'd0,
    CFG_ANCHOR_Y   = 3'd1,
    CFG_HALF_W     = 3'd2,
    CFG_HALF_H     = 3'd3,
    CFG_STOP_COUNT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    op_e                operation;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [IDX_W-1:0]   stop_index;
    logic [POS_W-1:0]   stop_position;
    logic [COLOR_W-1:0] stop_red;
    logic [COLOR_W-1:0] stop_green;
    logic [COLOR_W-1:0] stop_blue;
  } req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [POS_W-1:0]   ramp_value;
  } rsp_t;

  // index 2 is red, 0 is blue
  typedef logic [2:0][COLOR_W-1:0] rgb_t;

  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    rgb_t             col;
  } ctl_t;

  typedef struct packed {
    logic [D2_W-1:0] d2;
    logic [D2_W-1:0] r2;
  } dist_t;

  typedef struct packed {
    logic [D2_W-1:0] rem;
    logic [D2_W-1:0] r2;
    logic [Q_W-1:0]  q;
  } qdiv_t;

  typedef struct packed {
    logic [2*SQ_STEPS-1:0] rad;
    logic [SREM_W-1:0]     rem;
    logic [ROOT_W-1:0]     root;
  } sqrt_t;

  typedef struct packed {
    logic             found;
    rgb_t             c0;
    rgb_t             c1;
    logic [POS_W-1:0] p0;
    logic [POS_W-1:0] p1;
    logic [POS_W-1:0] v;
  } lut_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] rem;
    logic [POS_W-1:0]      den;
    rgb_t                  q;
    logic [POS_W-1:0]      v;
  } cdiv_t;

endpackage

// ===== rtl/core/radial_gradient_color_ramp.sv =====
// Radial gradient ramp with color stop interpolation, fully pipelined.
// The pipeline has 65 register stages; throughput is one request per cycle while the
// output is not stalled. The depth comes from the bit-serial distance/radius divider
// (35 stages), root (18) and color divider (8).
// A stalled output freezes the whole pipeline. Reset empties the pipeline and
// sets anchor 0,0, half sizes 1,1 and stop count 0; the stop table is not cleared.
`include "radial_gradient_color_ramp_defines.svh"

module radial_gradient_color_ramp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rgcr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rgcr_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rgcr_pkg::req_t                  in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rgcr_pkg::rsp_t                  out_rsp_o
);

  logic [rgcr_pkg::COORD_W-1:0] ax_q, ay_q, hw_q, hh_q;
  logic [rgcr_pkg::CNT_W-1:0]   cnt_q;

  logic [rgcr_pkg::POS_W-1:0] tbl_pos_q [rgcr_pkg::MAX_STOPS];
  rgcr_pkg::rgb_t             tbl_col_q [rgcr_pkg::MAX_STOPS];

  logic              en;
  rgcr_pkg::ctl_t    ctl_d;
  rgcr_pkg::ctl_t    ctl_q  [rgcr_pkg::N_POS];
  rgcr_pkg::dist_t   dist_d, dist_q;
  rgcr_pkg::qdiv_t   div_d  [rgcr_pkg::QF_BITS+1];
  rgcr_pkg::qdiv_t   div_q  [rgcr_pkg::QF_BITS+1];
  rgcr_pkg::sqrt_t   sq_d   [rgcr_pkg::SQ_STEPS];
  rgcr_pkg::sqrt_t   sq_q   [rgcr_pkg::SQ_STEPS];
  rgcr_pkg::lut_t    lut_d, lut_q;
  rgcr_pkg::cdiv_t   mix_d, mix_q;
  rgcr_pkg::cdiv_t   cdiv_d [rgcr_pkg::DIV_STEPS];
  rgcr_pkg::cdiv_t   cdiv_q [rgcr_pkg::DIV_STEPS];
  logic              out_valid_q;
  rgcr_pkg::rsp_t    out_rsp_q;

  // whole pipeline moves unless the output holds an untaken result
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q  <= '0;
      ay_q  <= '0;
      hw_q  <= rgcr_pkg::COORD_W'(1);
      hh_q  <= rgcr_pkg::COORD_W'(1);
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rgcr_pkg::cfg_idx_e'(cfg_idx_i))
        rgcr_pkg::CFG_ANCHOR_X:   ax_q  <= cfg_wdata_i;
        rgcr_pkg::CFG_ANCHOR_Y:   ay_q  <= cfg_wdata_i;
        rgcr_pkg::CFG_HALF_W:     hw_q  <= cfg_wdata_i;
        rgcr_pkg::CFG_HALF_H:     hh_q  <= cfg_wdata_i;
        rgcr_pkg::CFG_STOP_COUNT: cnt_q <= cfg_wdata_i[rgcr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // request control and stop payload entering the pipe
  always_comb begin
    ctl_d.valid = in_valid_i;
    ctl_d.op    = in_req_i.operation;
    ctl_d.idx   = in_req_i.stop_index;
    ctl_d.pos   = in_req_i.stop_position;
    ctl_d.col   = {in_req_i.stop_red, in_req_i.stop_green, in_req_i.stop_blue};
  end

  // stage 0: squared distance and squared radius
  logic signed [rgcr_pkg::COORD_W:0]     dx, dy;
  logic signed [2*rgcr_pkg::COORD_W+1:0] sq_x, sq_y;
  logic [2*rgcr_pkg::COORD_W-1:0]        hw2, hh2;
  always_comb begin
    dx = $signed({1'b0, in_req_i.pixel_x}) - $signed({1'b0, ax_q});
    dy = $signed({1'b0, in_req_i.pixel_y}) - $signed({1'b0, ay_q});
    sq_x = dx * dx;
    sq_y = dy * dy;
    hw2  = hw_q * hw_q;
    hh2  = hh_q * hh_q;
    dist_d.d2 = rgcr_pkg::D2_W'($unsigned(sq_x)) + rgcr_pkg::D2_W'($unsigned(sq_y));
    dist_d.r2 = {1'b0, hw2} + {1'b0, hh2};
  end

  // restoring divider: q = d2 * 2^34 / r2, one quotient bit per stage
  logic                  dz;
  logic [rgcr_pkg::D2_W-1:0] d2e, r2e;
  logic                  ib;
  logic [rgcr_pkg::D2_W:0] rem2 [rgcr_pkg::QF_BITS+1];
  logic                  ge   [rgcr_pkg::QF_BITS+1];
  always_comb begin
    // beyond the radius or zero radius collapses to a zero ratio
    dz  = (dist_q.r2 == '0) || (dist_q.d2 > dist_q.r2);
    d2e = dz ? '0 : dist_q.d2;
    r2e = dz ? rgcr_pkg::D2_W'(1) : dist_q.r2;
    ib  = (d2e >= r2e);
    div_d[0].r2  = r2e;
    div_d[0].rem = ib ? d2e - r2e : d2e;
    div_d[0].q   = rgcr_pkg::Q_W'(ib);
    rem2[0] = '0;
    ge[0]   = 1'b0;
    for (int j = 1; j <= rgcr_pkg::QF_BITS; j++) begin
      rem2[j] = {div_q[j-1].rem, 1'b0};
      ge[j]   = rem2[j] >= {1'b0, div_q[j-1].r2};
      div_d[j].r2  = div_q[j-1].r2;
      div_d[j].rem = ge[j] ? rgcr_pkg::D2_W'(rem2[j] - {1'b0, div_q[j-1].r2})
                           : rgcr_pkg::D2_W'(rem2[j]);
      div_d[j].q   = {div_q[j-1].q[rgcr_pkg::Q_W-2:0], ge[j]};
    end
  end

  // digit-by-digit integer square root, two radicand bits per stage
  rgcr_pkg::sqrt_t       sq_src [rgcr_pkg::SQ_STEPS];
  logic [rgcr_pkg::SREM_W+1:0] sq_cat [rgcr_pkg::SQ_STEPS];
  logic [rgcr_pkg::SREM_W-1:0] sq_t   [rgcr_pkg::SQ_STEPS];
  logic                  sq_ge  [rgcr_pkg::SQ_STEPS];
  always_comb begin
    for (int j = 0; j < rgcr_pkg::SQ_STEPS; j++) begin
      if (j == 0) begin
        sq_src[j].rad  = {1'b0, div_q[rgcr_pkg::QF_BITS].q};
        sq_src[j].rem  = '0;
        sq_src[j].root = '0;
      end else begin
        sq_src[j] = sq_q[j-1];
      end
      sq_cat[j] = {sq_src[j].rem, sq_src[j].rad[2*rgcr_pkg::SQ_STEPS-1 -: 2]};
      sq_t[j]   = {sq_src[j].root, 2'b01};
      sq_ge[j]  = sq_cat[j] >= {2'b00, sq_t[j]};
      sq_d[j].rad  = {sq_src[j].rad[2*rgcr_pkg::SQ_STEPS-3:0], 2'b00};
      sq_d[j].rem  = sq_ge[j] ? rgcr_pkg::SREM_W'(sq_cat[j] - {2'b00, sq_t[j]})
                              : rgcr_pkg::SREM_W'(sq_cat[j]);
      sq_d[j].root = {sq_src[j].root[rgcr_pkg::ROOT_W-2:0], sq_ge[j]};
    end
  end

  // ramp value: largest k with 2k-1 <= root, i.e. (root+1)/2
  logic [rgcr_pkg::ROOT_W:0] root_inc;
  logic [rgcr_pkg::POS_W-1:0] ramp;
  always_comb begin
    root_inc = {1'b0, sq_q[rgcr_pkg::SQ_STEPS-1].root} + 1'b1;
    ramp     = root_inc[rgcr_pkg::POS_W:1];
  end

  // stop lookup: first enclosing pair of neighbours, implicit black/white ends
  logic [rgcr_pkg::CNT_W-1:0] n_stops;
  logic                       has0, has1;
  logic [rgcr_pkg::POS_W-1:0] lo_p, hi_p;
  rgcr_pkg::rgb_t             lo_c, hi_c;
  logic                       pv;
  always_comb begin
    n_stops = (cnt_q > rgcr_pkg::CNT_W'(rgcr_pkg::MAX_STOPS))
            ? rgcr_pkg::CNT_W'(rgcr_pkg::MAX_STOPS) : cnt_q;
    has0 = 1'b0;
    has1 = 1'b0;
    for (int i = 0; i < rgcr_pkg::MAX_STOPS; i++) begin
      if (i < n_stops && tbl_pos_q[i] == '0)                has0 = 1'b1;
      if (i < n_stops && tbl_pos_q[i] == rgcr_pkg::POS_ONE) has1 = 1'b1;
    end
    lut_d.found = 1'b0;
    lut_d.c0    = '0;
    lut_d.c1    = '0;
    lut_d.p0    = '0;
    lut_d.p1    = '0;
    lut_d.v     = ramp;
    lo_p = '0;
    hi_p = '0;
    lo_c = '0;
    hi_c = '0;
    pv   = 1'b0;
    for (int p = 0; p <= rgcr_pkg::MAX_STOPS; p++) begin
      lo_p = (p == 0) ? '0 : tbl_pos_q[rgcr_pkg::IDX_W'(p-1)];
      lo_c = (p == 0) ? '0 : tbl_col_q[rgcr_pkg::IDX_W'(p-1)];
      hi_p = (p < n_stops) ? tbl_pos_q[rgcr_pkg::IDX_W'(p)] : rgcr_pkg::POS_ONE;
      hi_c = (p < n_stops) ? tbl_col_q[rgcr_pkg::IDX_W'(p)] : '1;
      pv   = ((p == 0) ? !has0 : (p <= n_stops)) && ((p < n_stops) || !has1);
      if (!lut_d.found && pv && ramp >= lo_p && ramp <= hi_p) begin
        lut_d.found = 1'b1;
        lut_d.c0    = lo_c;
        lut_d.c1    = hi_c;
        lut_d.p0    = lo_p;
        lut_d.p1    = hi_p;
      end
    end
  end

  // interpolation numerators, rounding half added
  logic [rgcr_pkg::POS_W-1:0] den, wa, wb;
  logic [rgcr_pkg::COLOR_W+rgcr_pkg::POS_W-1:0] prod0 [3];
  logic [rgcr_pkg::COLOR_W+rgcr_pkg::POS_W-1:0] prod1 [3];
  always_comb begin
    den = lut_q.p1 - lut_q.p0;
    wa  = lut_q.p1 - lut_q.v;
    wb  = lut_q.v - lut_q.p0;
    mix_d.v   = lut_q.v;
    mix_d.q   = '0;
    mix_d.den = den;
    for (int c = 0; c < 3; c++) begin
      prod0[c] = lut_q.c0[c] * wa;
      prod1[c] = lut_q.c1[c] * wb;
      mix_d.rem[c] = rgcr_pkg::NUM_W'(prod0[c]) + rgcr_pkg::NUM_W'(prod1[c])
                   + rgcr_pkg::NUM_W'(den >> 1);
    end
    if (!lut_q.found) begin
      // no enclosing pair: black
      mix_d.den = rgcr_pkg::POS_W'(1);
      mix_d.rem = '0;
    end else if (den == '0) begin
      // coincident stops: earlier stop's color
      mix_d.den = rgcr_pkg::POS_W'(1);
      for (int c = 0; c < 3; c++) begin
        mix_d.rem[c] = rgcr_pkg::NUM_W'(lut_q.c0[c]);
      end
    end
  end

  // restoring color divider, one quotient bit per stage for all channels
  rgcr_pkg::cdiv_t             cd_src [rgcr_pkg::DIV_STEPS];
  logic [rgcr_pkg::NUM_W-1:0]  cd_dsh [rgcr_pkg::DIV_STEPS];
  always_comb begin
    for (int j = 0; j < rgcr_pkg::DIV_STEPS; j++) begin
      cd_src[j] = (j == 0) ? mix_q : cdiv_q[j-1];
      cd_dsh[j] = rgcr_pkg::NUM_W'(cd_src[j].den) << (rgcr_pkg::DIV_STEPS - 1 - j);
      cdiv_d[j] = cd_src[j];
      for (int c = 0; c < 3; c++) begin
        if (cd_src[j].rem[c] >= cd_dsh[j]) begin
          cdiv_d[j].rem[c] = cd_src[j].rem[c] - cd_dsh[j];
          cdiv_d[j].q[c][rgcr_pkg::SH_W'(rgcr_pkg::DIV_STEPS - 1 - j)] = 1'b1;
        end
      end
    end
  end

  // control line and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < rgcr_pkg::N_POS; p++) begin
        ctl_q[p] <= '0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      ctl_q[0] <= ctl_d;
      for (int p = 1; p < rgcr_pkg::N_POS; p++) begin
        ctl_q[p] <= ctl_q[p-1];
      end
      out_valid_q <= ctl_q[rgcr_pkg::N_POS-1].valid &&
                     ctl_q[rgcr_pkg::N_POS-1].op == rgcr_pkg::OP_RENDER;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dist_d;
      for (int j = 0; j <= rgcr_pkg::QF_BITS; j++) begin
        div_q[j] <= div_d[j];
      end
      for (int j = 0; j < rgcr_pkg::SQ_STEPS; j++) begin
        sq_q[j] <= sq_d[j];
      end
      lut_q <= lut_d;
      mix_q <= mix_d;
      for (int j = 0; j < rgcr_pkg::DIV_STEPS; j++) begin
        cdiv_q[j] <= cdiv_d[j];
      end
      out_rsp_q.red        <= cdiv_q[rgcr_pkg::DIV_STEPS-1].q[2];
      out_rsp_q.green      <= cdiv_q[rgcr_pkg::DIV_STEPS-1].q[1];
      out_rsp_q.blue       <= cdiv_q[rgcr_pkg::DIV_STEPS-1].q[0];
      out_rsp_q.ramp_value <= cdiv_q[rgcr_pkg::DIV_STEPS-1].v;
    end
  end

  // stop writes take effect in order with renders, at the lookup stage
  always_ff @(posedge clk_i) begin
    if (en && ctl_q[rgcr_pkg::P_LUT-1].valid &&
        ctl_q[rgcr_pkg::P_LUT-1].op == rgcr_pkg::OP_WRITE) begin
      tbl_pos_q[ctl_q[rgcr_pkg::P_LUT-1].idx] <= ctl_q[rgcr_pkg::P_LUT-1].pos;
      tbl_col_q[ctl_q[rgcr_pkg::P_LUT-1].idx] <= ctl_q[rgcr_pkg::P_LUT-1].col;
    end
  end

  // checks
  `RGCR_ASSERT(a_ramp_range, out_valid_o, out_rsp_o.ramp_value <= rgcr_pkg::POS_ONE, "ramp above one")
  `RGCR_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, ctl_q[0].valid, "request lost at entry")
  `RGCR_ASSERT_NEXT(a_write_silent, en && ctl_q[rgcr_pkg::N_POS-1].valid && ctl_q[rgcr_pkg::N_POS-1].op == rgcr_pkg::OP_WRITE, !out_valid_o, "stop write produced a result")

endmodule
